// File: design/dep_pkg.sv
// ============================================================================
// dep_pkg: shared types and constants of the double-ended priority queue
// Entry slot, broadcast command and action codes used by the cell row.
// ============================================================================
package dep_pkg;

    localparam int KEY_W     = 32;
    localparam int PAY_W     = 32;
    localparam int ACT_W     = 2;
    localparam int COUNT_W   = 7;
    localparam int CAPACITY  = 64;
    localparam int GROUP     = 8;
    localparam int IN_BITS   = ACT_W + KEY_W + PAY_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 1 + KEY_W + PAY_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP_MIN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POP_MAX = 2'd2;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } t_slot;

    typedef struct packed {
        logic                    ins;
        logic                    pop_min;
        logic                    pop_max;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } t_cmd;

endpackage

// File: design/dep_cell.sv
// ============================================================================
// dep_cell: one slot of the sorted cell row
// Holds one entry and shifts it toward either neighbor on insert or pop.
// ============================================================================
module dep_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dep_pkg::t_cmd i_cmd,
    input  dep_pkg::t_slot i_prev,
    input  logic          i_prev_keep,
    input  dep_pkg::t_slot i_next,
    output dep_pkg::t_slot o_slot,
    output logic          o_keep
);

    dep_pkg::t_slot r_slot;
    dep_pkg::t_slot n_slot;

    assign o_keep = r_slot.valid && (r_slot.key <= i_cmd.key);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.ins) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_slot.valid   = 1'b1;
                    n_slot.key     = i_cmd.key;
                    n_slot.payload = i_cmd.payload;
                end else begin
                    n_slot = i_prev;
                end
            end
        end else if (i_cmd.pop_min) begin
            n_slot = i_next;
        end else if (i_cmd.pop_max) begin
            n_slot.valid = r_slot.valid && i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot.key     <= n_slot.key;
        r_slot.payload <= n_slot.payload;
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
    end

endmodule

// File: design/double_ended_priority_queue.sv
// ============================================================================
// double_ended_priority_queue: sorted multiset with min and max removal
// A row of cells keeps entries in ascending key order, ties in arrival order.
// ============================================================================
// Usage:
//   Requests enter on the s_axis channel; tdata carries action, key and
//   payload. Action 0 inserts, 1 pops the smallest key (oldest among ties),
//   2 pops the largest key (newest among ties). Every request yields one
//   response on m_axis with success, popped key and payload, and the count.
//   The cell row updates at the edge a request is accepted. The popped entry
//   is gathered by a two-level registered OR tree (groups of GROUP cells,
//   then across groups): group results register at accept, the final OR in
//   S_REDUCE, and the response is valid in S_SEND. One request is in flight
//   at a time; o_m_axis_tvalid waits on i_m_axis_tready while it is stalled.
//   A stalled response holds, and s_axis stays not ready until it is taken.
//   Synchronous reset empties the queue (all valid bits cleared).
// ============================================================================
module double_ended_priority_queue #(
    parameter int CAPACITY = dep_pkg::CAPACITY
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // action[1:0], key[33:2], payload[65:34], zero fill
    input  logic [dep_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // success[0], key_out[32:1], payload_out[64:33], count[71:65]
    output logic [dep_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NG    = (CAPACITY + dep_pkg::GROUP - 1) / dep_pkg::GROUP;
    localparam int ENT_W = dep_pkg::KEY_W + dep_pkg::PAY_W;

    typedef enum logic [1:0] {S_IDLE, S_REDUCE, S_SEND} t_state;

    t_state r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ok;
    logic             n_ok;
    logic [CNT_W-1:0] r_res_cnt;
    logic signed [dep_pkg::KEY_W-1:0] r_key_out;
    logic [dep_pkg::PAY_W-1:0]        r_pay_out;
    logic [ENT_W-1:0] r_grp [NG];
    logic [ENT_W-1:0] w_grp [NG];
    logic [ENT_W-1:0] w_red;

    logic [dep_pkg::ACT_W-1:0] w_action;
    logic        w_accept;
    logic        w_full;
    logic        w_empty;
    dep_pkg::t_cmd  w_cmd;
    dep_pkg::t_slot w_slot [CAPACITY];
    logic           w_keep [CAPACITY];
    logic [ENT_W-1:0] w_sel [CAPACITY];

    assign w_action = i_s_axis_tdata[dep_pkg::ACT_W-1:0];
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    always_comb begin
        w_cmd.ins     = w_accept && (w_action == dep_pkg::ACT_INSERT) && !w_full;
        w_cmd.pop_min = w_accept && (w_action == dep_pkg::ACT_POP_MIN) && !w_empty;
        w_cmd.pop_max = w_accept && (w_action == dep_pkg::ACT_POP_MAX) && !w_empty;
        w_cmd.key     = i_s_axis_tdata[dep_pkg::ACT_W +: dep_pkg::KEY_W];
        w_cmd.payload = i_s_axis_tdata[dep_pkg::ACT_W + dep_pkg::KEY_W +: dep_pkg::PAY_W];
    end

    always_comb begin
        n_ok    = w_cmd.ins || w_cmd.pop_min || w_cmd.pop_max;
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (w_cmd.pop_min || w_cmd.pop_max) begin
            n_count = r_count - 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            dep_pkg::t_slot w_prev;
            dep_pkg::t_slot w_next;
            logic           w_prev_keep;
            logic           w_top;

            if (g == 0) begin : g_first
                assign w_prev      = '0;
                assign w_prev_keep = 1'b1;
            end else begin : g_mid
                assign w_prev      = w_slot[g-1];
                assign w_prev_keep = w_keep[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_inner
                assign w_next = w_slot[g+1];
            end

            dep_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_prev      (w_prev),
                .i_prev_keep (w_prev_keep),
                .i_next      (w_next),
                .o_slot      (w_slot[g]),
                .o_keep      (w_keep[g])
            );

            // pick the head for pop-min, the topmost valid cell for pop-max
            assign w_top = (w_cmd.pop_min && (g == 0) && w_slot[g].valid)
                        || (w_cmd.pop_max && w_slot[g].valid && !w_next.valid);
            assign w_sel[g] = w_top ? {w_slot[g].key, w_slot[g].payload} : '0;
        end
    endgenerate

    always_comb begin
        for (int k = 0; k < NG; k++) begin
            w_grp[k] = '0;
            for (int j = 0; j < dep_pkg::GROUP; j++) begin
                if (k * dep_pkg::GROUP + j < CAPACITY) begin
                    w_grp[k] = w_grp[k] | w_sel[k * dep_pkg::GROUP + j];
                end
            end
        end
    end

    always_comb begin
        w_red = '0;
        for (int k = 0; k < NG; k++) begin
            w_red = w_red | r_grp[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int k = 0; k < NG; k++) begin
                r_grp[k] <= w_grp[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ok      <= 1'b0;
            r_res_cnt <= '0;
            r_key_out <= '0;
            r_pay_out <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count   <= n_count;
                        r_ok      <= n_ok;
                        r_res_cnt <= n_count;
                        r_state   <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    r_key_out <= w_red[ENT_W-1 -: dep_pkg::KEY_W];
                    r_pay_out <= w_red[dep_pkg::PAY_W-1:0];
                    r_state   <= S_SEND;
                end
                S_SEND: begin
                    if (i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_SEND);
    assign o_m_axis_tdata  = dep_pkg::OUT_DATA_W'({dep_pkg::COUNT_W'(r_res_cnt),
                                                   r_pay_out, r_key_out, r_ok});

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for double_ended_priority_queue
// Sends insert, pop-min, pop-max and unused-code requests on the slave stream,
// mirrors the sorted store in a scoreboard class and checks every response
// field by field, under three mixes of sender and receiver back-pressure.
// ============================================================================
module tb_top;

    localparam int ACT_W      = dep_pkg::ACT_W;
    localparam int KEY_W      = dep_pkg::KEY_W;
    localparam int PAY_W      = dep_pkg::PAY_W;
    localparam int COUNT_W    = dep_pkg::COUNT_W;
    localparam int CAPACITY   = dep_pkg::CAPACITY;
    localparam int IN_BITS    = dep_pkg::IN_BITS;
    localparam int IN_DATA_W  = dep_pkg::IN_DATA_W;
    localparam int OUT_BITS   = dep_pkg::OUT_BITS;
    localparam int OUT_DATA_W = dep_pkg::OUT_DATA_W;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1100;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } t_entry;

    typedef struct packed {
        logic                    success;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic [COUNT_W-1:0]      count;
    } t_response;

    class queue_tracker;
        t_entry    sorted_entries[$];
        t_response pending_responses[$];
        int        errors      = 0;
        int        requests    = 0;
        int        checked     = 0;
        int        refused     = 0;
        int        empty_pops  = 0;
        int        unused_reqs = 0;
        int        peak_depth  = 0;

        function void note_request(logic [ACT_W-1:0] action, logic signed [KEY_W-1:0] req_key,
                                   logic [PAY_W-1:0] req_payload);
            t_response r;
            t_entry    e;
            int        pos;
            r = '0;
            requests++;
            case (action)
                dep_pkg::ACT_INSERT: begin
                    if (sorted_entries.size() < CAPACITY) begin
                        pos = 0;
                        while (pos < sorted_entries.size() &&
                               $signed(sorted_entries[pos].key) <= req_key)
                            pos++;
                        e.key     = req_key;
                        e.payload = req_payload;
                        sorted_entries.insert(pos, e);
                        r.success = 1'b1;
                    end else begin
                        refused++;
                    end
                end
                dep_pkg::ACT_POP_MIN, dep_pkg::ACT_POP_MAX: begin
                    if (sorted_entries.size() > 0) begin
                        if (action == dep_pkg::ACT_POP_MIN)
                            e = sorted_entries.pop_front();
                        else
                            e = sorted_entries.pop_back();
                        r.success = 1'b1;
                        r.key     = e.key;
                        r.payload = e.payload;
                    end else begin
                        empty_pops++;
                    end
                end
                default: unused_reqs++;
            endcase
            r.count = COUNT_W'(sorted_entries.size());
            if (sorted_entries.size() > peak_depth)
                peak_depth = sorted_entries.size();
            pending_responses.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_response(logic [OUT_DATA_W-1:0] data);
            t_response got;
            t_response want;
            got.success = data[0];
            got.key     = data[KEY_W:1];
            got.payload = data[KEY_W+PAY_W:KEY_W+1];
            got.count   = data[OUT_BITS-1:KEY_W+PAY_W+1];
            if (pending_responses.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: response with nothing outstanding, expected none actual %h",
                             $time, data);
                return;
            end
            want = pending_responses.pop_front();
            checked++;
            compare_field("success", 32'(want.success), 32'(got.success));
            compare_field("key_out", want.key, got.key);
            compare_field("payload_out", want.payload, got.payload);
            compare_field("count", 32'(want.count), 32'(got.count));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;

    queue_tracker tracker = new;

    double_ended_priority_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // note requests before checking responses so the order never depends on scheduling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_cycles    <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                tracker.note_request(i_s_axis_tdata[ACT_W-1:0],
                                     i_s_axis_tdata[ACT_W+KEY_W-1:ACT_W],
                                     i_s_axis_tdata[IN_BITS-1:ACT_W+KEY_W]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                tracker.check_response(o_m_axis_tdata);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_request(logic [ACT_W-1:0] action, logic signed [KEY_W-1:0] req_key,
                                logic [PAY_W-1:0] req_payload);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_DATA_W-IN_BITS){1'b0}}, req_payload, req_key, action};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // favor a narrow band so equal keys are common, with the extremes mixed in
    function automatic logic signed [KEY_W-1:0] random_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return KEY_W'($urandom_range(16)) - KEY_W'(8);
        if (pick < 70) begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sh8000_0001;
                default: return 32'sh7fff_fffe;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [ACT_W-1:0] random_action(int insert_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < insert_pct)
            return dep_pkg::ACT_INSERT;
        if (pick >= 96)
            return ACT_UNUSED;
        return $urandom_range(1) ? dep_pkg::ACT_POP_MIN : dep_pkg::ACT_POP_MAX;
    endfunction

    initial begin : stimulus
        int sent;
        int burst_len;
        int insert_pct;
        int target;
        send_idle_pct = 23;
        recv_idle_pct = 72;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(dep_pkg::ACT_POP_MIN, 32'sd0, 32'h0);
        send_request(dep_pkg::ACT_POP_MAX, 32'sd0, 32'h0);
        send_request(ACT_UNUSED, -32'sd1, 32'hffff_ffff);
        send_request(dep_pkg::ACT_INSERT, 32'sh7fff_ffff, 32'h0000_0000);
        send_request(dep_pkg::ACT_INSERT, 32'sh8000_0000, 32'hffff_ffff);
        send_request(dep_pkg::ACT_INSERT, 32'sd0, 32'h5555_5555);
        send_request(dep_pkg::ACT_INSERT, -32'sd1, 32'haaaa_aaaa);
        send_request(dep_pkg::ACT_INSERT, 32'sd5, 32'h1);
        send_request(dep_pkg::ACT_INSERT, 32'sd5, 32'h2);
        send_request(dep_pkg::ACT_INSERT, 32'sd5, 32'h3);
        send_request(ACT_UNUSED, 32'sd5, 32'h9);
        send_request(dep_pkg::ACT_POP_MIN, 32'sd0, 32'h0);
        send_request(dep_pkg::ACT_POP_MAX, 32'sd0, 32'h0);
        send_request(dep_pkg::ACT_POP_MIN, 32'sd0, 32'h0);
        send_request(dep_pkg::ACT_POP_MAX, 32'sd0, 32'h0);
        send_request(dep_pkg::ACT_POP_MIN, 32'sd0, 32'h0);
        send_request(dep_pkg::ACT_POP_MIN, 32'sd0, 32'h0);
        send_request(dep_pkg::ACT_INSERT, 32'sd5, 32'h4);
        send_request(dep_pkg::ACT_POP_MAX, 32'sd0, 32'h0);
        send_request(dep_pkg::ACT_POP_MAX, 32'sd0, 32'h0);
        send_request(dep_pkg::ACT_POP_MAX, 32'sd0, 32'h0);

        target = RANDOM_ITEMS / 3;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 23;
                    recv_idle_pct = 72;
                end
                1: begin
                    send_idle_pct = 72;
                    recv_idle_pct = 23;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < target) begin
                burst_len = $urandom_range(110, 20);
                case ($urandom_range(2))
                    0:       insert_pct = 80;
                    1:       insert_pct = 20;
                    default: insert_pct = 48;
                endcase
                for (int i = 0; i < burst_len && sent < target; i++) begin
                    send_request(random_action(insert_pct), random_key(), $urandom);
                    sent++;
                end
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (tracker.pending_responses.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests, %0d responses checked, peak depth %0d of %0d",
                 tracker.requests, tracker.checked, tracker.peak_depth, CAPACITY);
        $display("inserts refused when full %0d, pops on empty %0d, unused action %0d",
                 tracker.refused, tracker.empty_pops, tracker.unused_reqs);
        if (tracker.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
design/dep_pkg.sv
design/dep_cell.sv
design/double_ended_priority_queue.sv
sim/tb_top.sv
